// ===== src/mse_pkg.sv =====
`timescale 1ns / 1ps
// Shared definitions for the MIPS subset executor: opcodes, function codes,
// fixed addresses and the execute result record. No dependencies.
package mse_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SW      = 6'h2b;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLTU    = 6'h2b;

  localparam logic [31:0] TEXT_BASE      = 32'h0040_0000;
  localparam logic [31:0] PC_REGION_MASK = 32'hF000_0000;
  localparam logic [31:0] IMM_HI_MASK    = 32'hFFFF_0000;
  localparam logic [4:0]  LINK_REG       = 5'd31;
  localparam int unsigned TEXT_BYTES_W   = 25;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        load;
    logic        store;
    logic [31:0] mem_addr;
  } exec_t;

endpackage

// ===== src/mse_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
module mse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mse_exec.sv =====
`timescale 1ns / 1ps
// Execute unit: decodes one instruction and computes the new PC, the register
// write and the memory address. Depends on mse_pkg.
module mse_exec
  import mse_pkg::*;
(
  input  logic [31:0] word_i,
  input  logic [31:0] rs_val_i,
  input  logic [31:0] rt_val_i,
  input  logic [31:0] pc_i,
  output exec_t       res_o
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] br_target;

  assign op        = word_i[31:26];
  assign rt        = word_i[20:16];
  assign rd        = word_i[15:11];
  assign sh        = word_i[10:6];
  assign fn        = word_i[5:0];
  assign zimm      = {16'h0000, word_i[15:0]};
  assign simm      = word_i[15] ? (zimm | IMM_HI_MASK) : zimm;
  assign pc4       = pc_i + 32'd4;
  assign br_target = pc4 + {simm[29:0], 2'b00};

  always_comb begin
    exec_t r;
    r          = '0;
    r.next_pc  = pc4;
    r.mem_addr = rs_val_i + simm;
    if (op == OP_SPECIAL) begin
      r.idx = rd;
      r.wr  = 1'b1;
      case (fn)
        FN_ADDU: r.val = rs_val_i + rt_val_i;
        FN_AND:  r.val = rs_val_i & rt_val_i;
        FN_NOR:  r.val = ~(rs_val_i | rt_val_i);
        FN_OR:   r.val = rs_val_i | rt_val_i;
        FN_SLTU: r.val = {31'd0, rs_val_i < rt_val_i};
        FN_SLL:  r.val = rt_val_i << sh;
        FN_SRL:  r.val = rt_val_i >> sh;
        FN_SUBU: r.val = rs_val_i - rt_val_i;
        FN_JR: begin
          r.next_pc = rs_val_i;
          r.wr      = 1'b0;
        end
        default: r.wr = 1'b0;
      endcase
    end else if (op == OP_J || op == OP_JAL) begin
      r.next_pc = (pc4 & PC_REGION_MASK) | {4'h0, word_i[25:0], 2'b00};
      if (op == OP_JAL) begin
        r.idx = LINK_REG;
        r.val = pc4;
        r.wr  = 1'b1;
      end
    end else begin
      r.idx = rt;
      r.wr  = 1'b1;
      case (op)
        OP_ADDIU: r.val = rs_val_i + simm;
        OP_ANDI:  r.val = rs_val_i & zimm;
        OP_LUI:   r.val = {word_i[15:0], 16'h0000};
        OP_LW:    r.load = 1'b1;
        OP_ORI:   r.val = rs_val_i | zimm;
        OP_SLTIU: r.val = {31'd0, rs_val_i < simm};
        OP_BEQ: begin
          r.wr = 1'b0;
          if (rs_val_i == rt_val_i) begin
            r.next_pc = br_target;
          end
        end
        OP_BNE: begin
          r.wr = 1'b0;
          if (rs_val_i != rt_val_i) begin
            r.next_pc = br_target;
          end
        end
        OP_SW: begin
          r.wr    = 1'b0;
          r.store = 1'b1;
        end
        default: r.wr = 1'b0;
      endcase
    end
    if (r.idx == 5'd0) begin
      r.wr = 1'b0;
    end
    if (!r.wr) begin
      r.idx = 5'd0;
      r.val = 32'd0;
    end
    res_o = r;
  end

endmodule

// ===== src/mips_subset_executor.sv =====
`timescale 1ns / 1ps
// Top level of the MIPS subset executor: register file, PC, byte data memory
// and the three-step pipeline. Depends on mse_pkg, mse_ram and mse_exec.
//
// Items arrive on the s_axis channel: tuser is the mode (0 execute the word,
// 1 preload the word into data memory at the given byte address). Each item
// gives one result on the m_axis channel with the next PC, the register write,
// the memory-write flag and whether the PC left the text region.
// The cfg channel writes the text region size and is always ready. The user
// must write it only while no item is in flight; the block does not check.
// An item passes the s1 and s2 registers to its result; one item is taken every
// cycle while no result waits. The register file is a pair of synchronous RAMs
// read when an item is accepted, with bypass from the result stage and last write.
// The data memory is four byte-lane RAMs, so any unaligned word is one access;
// loads and stores both use the lanes in the same step, keeping them in order.
// After reset the block sweeps all 2**(MEM_ADDR_BITS-2) rows of data memory to
// zero with s_axis_tready low; register file and PC reset at once.
// While a result waits with m_axis_tready low the whole pipeline holds and
// s_axis_tready drops.
module mips_subset_executor
  import mse_pkg::*;
#(
  parameter int unsigned MEM_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // word[31:0], address[63:32]
  input  logic [0:0]  s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[31:0], reg_written[32], reg_index[37:33], reg_value[69:38],
  // mem_written[70], outside_text[71]
  output logic [71:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [TEXT_BYTES_W-1:0] cfg_data_i
);

  localparam int unsigned ROW_W = MEM_ADDR_BITS - 2;
  localparam int unsigned ROWS  = 2 ** ROW_W;

  logic                    en;
  logic [TEXT_BYTES_W-1:0] text_bytes_q;
  logic [31:0]             pc_q;
  logic                    clr_busy_q;
  logic [ROW_W-1:0]        clr_row_q;

  logic        s1_valid_q;
  logic        s1_mode_q;
  logic [31:0] s1_word_q;
  logic [31:0] s1_addr_q;

  logic        s2_valid_q;
  logic [31:0] s2_pc_q;
  logic        s2_wr_q;
  logic [4:0]  s2_idx_q;
  logic [31:0] s2_val_q;
  logic        s2_mw_q;
  logic        s2_load_q;
  logic [1:0]  s2_k_q;
  logic [31:0] s2_wval;
  logic [31:0] load_word;
  logic        outside;

  logic [31:0] rf_valid_q;
  logic        w3_valid_q;
  logic [4:0]  w3_idx_q;
  logic [31:0] w3_val_q;
  logic        rf_we;
  logic [31:0] rf_rdata_a;
  logic [31:0] rf_rdata_b;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [31:0] a_val;
  logic [31:0] b_val;

  exec_t       ex;
  logic [31:0] maddr;
  logic [31:0] mwdata;
  logic        mem_we;
  logic [1:0]  mk;
  logic [ROW_W-1:0] mrow;
  logic [ROW_W-1:0] lane_addr  [4];
  logic [7:0]       lane_wdata [4];
  logic [7:0]       lane_rdata [4];

  assign en            = !s2_valid_q || m_axis_tready;
  assign s_axis_tready = en && !clr_busy_q;
  assign cfg_ready_o   = 1'b1;

  // Register file read at transfer time, bypassed in the execute step.
  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_idx_q),
    .wdata_i (s2_wval),
    .re_i    (en),
    .raddr_i (s_axis_tdata[25:21]),
    .rdata_o (rf_rdata_a)
  );

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s2_idx_q),
    .wdata_i (s2_wval),
    .re_i    (en),
    .raddr_i (s_axis_tdata[20:16]),
    .rdata_o (rf_rdata_b)
  );

  assign rs = s1_word_q[25:21];
  assign rt = s1_word_q[20:16];

  always_comb begin
    if (s2_valid_q && s2_wr_q && s2_idx_q == rs) begin
      a_val = s2_wval;
    end else if (w3_valid_q && w3_idx_q == rs) begin
      a_val = w3_val_q;
    end else if (rf_valid_q[rs]) begin
      a_val = rf_rdata_a;
    end else begin
      a_val = 32'd0;
    end
    if (s2_valid_q && s2_wr_q && s2_idx_q == rt) begin
      b_val = s2_wval;
    end else if (w3_valid_q && w3_idx_q == rt) begin
      b_val = w3_val_q;
    end else if (rf_valid_q[rt]) begin
      b_val = rf_rdata_b;
    end else begin
      b_val = 32'd0;
    end
  end

  mse_exec u_exec (
    .word_i   (s1_word_q),
    .rs_val_i (a_val),
    .rt_val_i (b_val),
    .pc_i     (pc_q),
    .res_o    (ex)
  );

  // Data memory: byte lane L holds the bytes whose address ends in L.
  assign maddr  = s1_mode_q ? s1_addr_q : ex.mem_addr;
  assign mwdata = s1_mode_q ? s1_word_q : b_val;
  assign mem_we = en && s1_valid_q && (s1_mode_q || ex.store);
  assign mk     = maddr[1:0];
  assign mrow   = maddr[MEM_ADDR_BITS-1:2];

  for (genvar ln = 0; ln < 4; ln++) begin : g_lane
    logic [1:0] lane_j;
    assign lane_j = 2'(ln) - mk;
    always_comb begin
      if (clr_busy_q) begin
        lane_addr[ln]  = clr_row_q;
        lane_wdata[ln] = 8'h00;
      end else begin
        lane_addr[ln]  = (2'(ln) >= mk) ? mrow : ROW_W'(mrow + 1'b1);
        lane_wdata[ln] = mwdata[{~lane_j, 3'b000} +: 8];
      end
    end

    mse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
      .clk_i   (clk_i),
      .we_i    (clr_busy_q || mem_we),
      .waddr_i (lane_addr[ln]),
      .wdata_i (lane_wdata[ln]),
      .re_i    (en),
      .raddr_i (lane_addr[ln]),
      .rdata_o (lane_rdata[ln])
    );
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      load_word[8*(3-j) +: 8] = lane_rdata[2'(s2_k_q + 2'(j))];
    end
  end

  assign s2_wval = (s2_wr_q && s2_load_q) ? load_word : s2_val_q;
  assign rf_we   = en && s2_valid_q && s2_wr_q;

  assign outside = (s2_pc_q < TEXT_BASE) ||
                   ({1'b0, s2_pc_q} >= ({1'b0, TEXT_BASE} + 33'(text_bytes_q)));

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {outside, s2_mw_q, s2_wval, s2_idx_q, s2_wr_q, s2_pc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_bytes_q <= '0;
      pc_q         <= TEXT_BASE;
      clr_busy_q   <= 1'b1;
      clr_row_q    <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      rf_valid_q   <= '0;
      w3_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        text_bytes_q <= cfg_data_i;
      end
      if (clr_busy_q) begin
        clr_row_q <= ROW_W'(clr_row_q + 1'b1);
        if (clr_row_q == ROW_W'(ROWS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (en) begin
        s1_valid_q <= s_axis_tvalid && s_axis_tready;
        s2_valid_q <= s1_valid_q;
        if (s1_valid_q && !s1_mode_q) begin
          pc_q <= ex.next_pc;
        end
      end
      if (rf_we) begin
        rf_valid_q[s2_idx_q] <= 1'b1;
        w3_valid_q           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_mode_q <= s_axis_tuser[0];
        s1_word_q <= s_axis_tdata[31:0];
        s1_addr_q <= s_axis_tdata[63:32];
      end
      s2_k_q <= mk;
      if (s1_mode_q) begin
        s2_pc_q   <= pc_q;
        s2_wr_q   <= 1'b0;
        s2_idx_q  <= 5'd0;
        s2_val_q  <= 32'd0;
        s2_mw_q   <= 1'b1;
        s2_load_q <= 1'b0;
      end else begin
        s2_pc_q   <= ex.next_pc;
        s2_wr_q   <= ex.wr;
        s2_idx_q  <= ex.idx;
        s2_val_q  <= ex.val;
        s2_mw_q   <= ex.store;
        s2_load_q <= ex.load;
      end
    end
    if (rf_we) begin
      w3_idx_q <= s2_idx_q;
      w3_val_q <= s2_wval;
    end
  end

endmodule
